/* rtl/core/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Beat types, status codes and the constants of the decode and range checks.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int ACC_BITS = 21;
   localparam int WIDTH_BITS = 3;
   localparam int STATUS_BITS = 3;
   localparam int OUT_OFFSET_BITS = 32;

   typedef logic [ACC_BITS-1:0] scalar_type;
   typedef logic [WIDTH_BITS-1:0] width_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK = 3'd0,
      ST_BAD_LEAD = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_BAD_CONT = 3'd3,
      ST_NON_CANONICAL = 3'd4
   } status_type;

   localparam width_type WIDTH_NONE = 3'd0;
   localparam width_type WIDTH_ONE = 3'd1;
   localparam width_type WIDTH_TWO = 3'd2;
   localparam width_type WIDTH_THREE = 3'd3;
   localparam width_type WIDTH_FOUR = 3'd4;

   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG = 8'h80;

   localparam scalar_type MIN_TWO = 21'h000080;
   localparam scalar_type MIN_THREE = 21'h000800;
   localparam scalar_type MIN_FOUR = 21'h010000;
   localparam scalar_type MAX_SCALAR = 21'h10FFFF;
   localparam scalar_type SURR_LO = 21'h00D800;
   localparam scalar_type SURR_HI = 21'h00DFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic final_byte;
   } req_type;

   typedef struct packed {
      logic [ACC_BITS-1:0] code_point;
      logic [OUT_OFFSET_BITS-1:0] start_offset;
      logic [OUT_OFFSET_BITS-1:0] end_offset;
      logic [STATUS_BITS-1:0] status;
      logic last_result;
   } rsp_type;

endpackage

/* rtl/core/utf8_validating_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes a byte stream into code points with byte offsets and reports the
// first malformed sequence of each text, then drops bytes to the final byte.
// ----------------------------------------------------------------------------
// Timing: an accepted byte beat is held in the input register and decoded
//    out of it; any result it completes is registered and driven onto rsp.
// Throughput: one byte per cycle unless a result waits on a stalled result
//    register; set by the single-pass decode from input to result register.
// Reset: synchronous; clears both beat valid flags and all decode state.
module utf8_validating_decoder
   import utf8d_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_payload
);

   typedef logic [OFFSET_BITS-1:0] offset_type;

   logic in_valid_ff, in_valid_in;
   req_type in_beat_ff;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_beat_ff, rsp_beat_in;

   offset_type byte_position_ff, byte_position_in;
   offset_type sequence_start_ff, sequence_start_in;
   scalar_type accumulator_ff, accumulator_in;
   width_type expected_width_ff, expected_width_in;
   width_type bytes_seen_ff, bytes_seen_in;
   logic pending_error_ff, pending_error_in;
   logic discarding_ff, discarding_in;

   logic emit;
   logic out_free;
   logic advance;
   offset_type pos, nxt, res_start;
   scalar_type lead_value, cont_value, res_value;
   width_type lead_width, seen_next;
   status_type res_status;
   logic res_last;
   logic [63:0] start_wide, end_wide;
   logic fin;
   logic [7:0] b;

   assign b = in_beat_ff.data_byte;
   assign fin = in_beat_ff.final_byte;
   assign pos = byte_position_ff;
   assign nxt = byte_position_ff + offset_type'(1);

   always_comb begin
      lead_width = WIDTH_NONE;
      lead_value = '0;
      case (b) inside
         [8'h00:8'h7F]: begin
            lead_width = WIDTH_ONE;
            lead_value = scalar_type'(b);
         end
         [8'hC0:8'hDF]: begin
            lead_width = WIDTH_TWO;
            lead_value = scalar_type'(b[4:0]);
         end
         [8'hE0:8'hEF]: begin
            lead_width = WIDTH_THREE;
            lead_value = scalar_type'(b[3:0]);
         end
         [8'hF0:8'hF7]: begin
            lead_width = WIDTH_FOUR;
            lead_value = scalar_type'(b[2:0]);
         end
         default: begin
            lead_width = WIDTH_NONE;
            lead_value = '0;
         end
      endcase
   end

   assign cont_value = {accumulator_ff[ACC_BITS-7:0], b[5:0]};
   assign seen_next = bytes_seen_ff + WIDTH_ONE;

   always_comb begin
      byte_position_in = byte_position_ff;
      sequence_start_in = sequence_start_ff;
      accumulator_in = accumulator_ff;
      expected_width_in = expected_width_ff;
      bytes_seen_in = bytes_seen_ff;
      pending_error_in = pending_error_ff;
      discarding_in = discarding_ff;
      emit = 1'b0;
      res_value = '0;
      res_start = pos;
      res_status = ST_OK;
      res_last = 1'b0;

      if (discarding_ff) begin
         if (fin) begin
            byte_position_in = '0;
            sequence_start_in = '0;
            accumulator_in = '0;
            discarding_in = 1'b0;
         end
      end else if (expected_width_ff == WIDTH_NONE) begin
         emit = 1'b1;
         res_start = pos;
         if (lead_width == WIDTH_NONE) begin
            res_status = ST_BAD_LEAD;
            res_last = 1'b1;
            discarding_in = !fin;
         end else if (lead_width == WIDTH_ONE) begin
            res_value = lead_value;
            res_last = fin;
         end else if (fin) begin
            res_status = ST_TRUNCATED;
            res_last = 1'b1;
         end else begin
            emit = 1'b0;
            sequence_start_in = pos;
            accumulator_in = lead_value;
            expected_width_in = lead_width;
            bytes_seen_in = WIDTH_ONE;
            pending_error_in = 1'b0;
         end
         if (emit && fin) begin
            sequence_start_in = '0;
            accumulator_in = '0;
         end
         byte_position_in = fin ? offset_type'(0) : nxt;
      end else begin
         if ((b & CONT_MASK) != CONT_TAG) begin
            pending_error_in = 1'b1;
         end else begin
            accumulator_in = cont_value;
         end
         bytes_seen_in = seen_next;
         res_start = sequence_start_ff;
         if (seen_next >= expected_width_ff) begin
            emit = 1'b1;
            res_last = 1'b1;
            if (pending_error_in) begin
               res_status = ST_BAD_CONT;
            end else if ((expected_width_ff == WIDTH_TWO && accumulator_in < MIN_TWO) ||
                         (expected_width_ff == WIDTH_THREE && accumulator_in < MIN_THREE) ||
                         (expected_width_ff == WIDTH_FOUR && accumulator_in < MIN_FOUR) ||
                         accumulator_in > MAX_SCALAR ||
                         (accumulator_in >= SURR_LO && accumulator_in <= SURR_HI)) begin
               res_status = ST_NON_CANONICAL;
            end else begin
               res_value = accumulator_in;
               res_last = fin;
            end
            discarding_in = (res_status != ST_OK) && !fin;
            expected_width_in = WIDTH_NONE;
            bytes_seen_in = WIDTH_NONE;
            pending_error_in = 1'b0;
            byte_position_in = fin ? offset_type'(0) : nxt;
            if (fin) begin
               sequence_start_in = '0;
               accumulator_in = '0;
            end
         end else if (fin) begin
            emit = 1'b1;
            res_status = ST_TRUNCATED;
            res_last = 1'b1;
            byte_position_in = '0;
            sequence_start_in = '0;
            accumulator_in = '0;
            expected_width_in = WIDTH_NONE;
            bytes_seen_in = WIDTH_NONE;
            pending_error_in = 1'b0;
         end else begin
            byte_position_in = nxt;
         end
      end
   end

   assign start_wide = 64'(res_start);
   assign end_wide = 64'(nxt);

   always_comb begin
      rsp_beat_in.code_point = res_value;
      rsp_beat_in.start_offset = start_wide[OUT_OFFSET_BITS-1:0];
      rsp_beat_in.end_offset = end_wide[OUT_OFFSET_BITS-1:0];
      rsp_beat_in.status = res_status;
      rsp_beat_in.last_result = res_last;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = out_free ? (advance && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byte_position_ff <= '0;
         sequence_start_ff <= '0;
         accumulator_ff <= '0;
         expected_width_ff <= WIDTH_NONE;
         bytes_seen_ff <= WIDTH_NONE;
         pending_error_ff <= 1'b0;
         discarding_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            byte_position_ff <= byte_position_in;
            sequence_start_ff <= sequence_start_in;
            accumulator_ff <= accumulator_in;
            expected_width_ff <= expected_width_in;
            bytes_seen_ff <= bytes_seen_in;
            pending_error_ff <= pending_error_in;
            discarding_ff <= discarding_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_beat_ff <= req_payload;
      end
      if (advance && emit) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

   a_discard_closed: assert property (@(posedge clock) disable iff (reset)
      discarding_ff |-> expected_width_ff == WIDTH_NONE)
      else $error("sequence open while dropping bytes");

   a_seen_in_range: assert property (@(posedge clock) disable iff (reset)
      expected_width_ff != WIDTH_NONE |->
         bytes_seen_ff != WIDTH_NONE && bytes_seen_ff < expected_width_ff)
      else $error("byte count outside open sequence");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      expected_width_ff == WIDTH_NONE |->
         bytes_seen_ff == WIDTH_NONE && !pending_error_ff)
      else $error("stale sequence state with no sequence open");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.status != ST_OK |->
         rsp_beat_ff.last_result && rsp_beat_ff.code_point == '0)
      else $error("error beat not marked last or carries a value");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && emit && !out_free |=> in_valid_ff && $stable(in_beat_ff))
      else $error("input beat lost while result register full");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 validating decoder bench
// Drives byte texts into the decoder and scores every result beat against a
// cycle-free decode of the same bytes. It first runs directed texts for the
// valid forms and each error class, then a long hold on the result side, then
// random texts: mostly well-formed, some broken, some noise. Sender bursts and
// receiver stall patterns vary throughout.
// ----------------------------------------------------------------------------
module tb_top;
   import utf8d_pkg::*;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // decode state of the bench
   logic [31:0] dec_pos;
   logic [31:0] dec_start;
   scalar_type dec_acc;
   width_type dec_width;
   width_type dec_seen;
   logic dec_bad_cont;
   logic dec_dropping;

   rsp_type pending_points[$];
   logic [7:0] text_bytes[$];
   rsp_type want;
   int error_count = 0;
   int beats_sent = 0;
   int burst_left = 0;
   int gap_max = 3;
   int drain_cycles;

   int hold_asked = 0;
   int hold_done = 0;
   int hold_cycles = 0;
   int mode_cycles = 0;
   int phase_count = 0;
   stall_kind_type stall_mode = STALL_NONE;

   always #4 clock = ~clock;

   utf8_validating_decoder u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   function automatic void clear_decoder();
      dec_pos = '0;
      dec_start = '0;
      dec_acc = '0;
      dec_width = WIDTH_NONE;
      dec_seen = '0;
      dec_bad_cont = 1'b0;
      dec_dropping = 1'b0;
   endfunction

   function automatic void close_sequence(input logic fin, input logic [31:0] nxt);
      dec_width = WIDTH_NONE;
      dec_seen = '0;
      dec_bad_cont = 1'b0;
      if (fin) begin
         clear_decoder();
      end else begin
         dec_pos = nxt;
      end
   endfunction

   function automatic void fail_sequence(input logic fin, input logic [31:0] nxt);
      close_sequence(fin, nxt);
      if (!fin) begin
         dec_dropping = 1'b1;
      end
   endfunction

   function automatic void push_point(input scalar_type cp, input logic [31:0] s,
                                      input logic [31:0] e, input status_type st,
                                      input logic last);
      rsp_type r;
      r.code_point = cp;
      r.start_offset = s;
      r.end_offset = e;
      r.status = st;
      r.last_result = last;
      pending_points.insert(pending_points.size(), r);
   endfunction

   function automatic void append_byte(input logic [7:0] v);
      text_bytes.insert(text_bytes.size(), v);
   endfunction

   function automatic void decode_byte(input req_type beat);
      logic [7:0] b;
      logic fin;
      logic [31:0] pos;
      logic [31:0] nxt;
      scalar_type v;
      width_type w;
      status_type st;
      b = beat.data_byte;
      fin = beat.final_byte;
      pos = dec_pos;
      nxt = pos + 32'd1;
      if (dec_dropping) begin
         if (fin) begin
            clear_decoder();
         end
         return;
      end
      if (dec_width == WIDTH_NONE) begin
         if (b < 8'h80) begin
            w = WIDTH_ONE;
            v = scalar_type'(b);
         end else if ((b & 8'hE0) == 8'hC0) begin
            w = WIDTH_TWO;
            v = scalar_type'(b & 8'h1F);
         end else if ((b & 8'hF0) == 8'hE0) begin
            w = WIDTH_THREE;
            v = scalar_type'(b & 8'h0F);
         end else if ((b & 8'hF8) == 8'hF0) begin
            w = WIDTH_FOUR;
            v = scalar_type'(b & 8'h07);
         end else begin
            push_point('0, pos, nxt, ST_BAD_LEAD, 1'b1);
            fail_sequence(fin, nxt);
            return;
         end
         if (w == WIDTH_ONE) begin
            push_point(v, pos, nxt, ST_OK, fin);
            close_sequence(fin, nxt);
         end else if (fin) begin
            push_point('0, pos, nxt, ST_TRUNCATED, 1'b1);
            clear_decoder();
         end else begin
            dec_start = pos;
            dec_acc = v;
            dec_width = w;
            dec_seen = WIDTH_ONE;
            dec_bad_cont = 1'b0;
            dec_pos = nxt;
         end
         return;
      end
      if ((b & CONT_MASK) != CONT_TAG) begin
         dec_bad_cont = 1'b1;
      end else begin
         dec_acc = {dec_acc[ACC_BITS-7:0], b[5:0]};
      end
      dec_seen = dec_seen + 1'b1;
      if (dec_seen >= dec_width) begin
         v = dec_acc;
         if (dec_bad_cont) begin
            st = ST_BAD_CONT;
         end else if ((dec_width == WIDTH_TWO && v < MIN_TWO) ||
                      (dec_width == WIDTH_THREE && v < MIN_THREE) ||
                      (dec_width == WIDTH_FOUR && v < MIN_FOUR) ||
                      v > MAX_SCALAR || (v >= SURR_LO && v <= SURR_HI)) begin
            st = ST_NON_CANONICAL;
         end else begin
            st = ST_OK;
         end
         if (st != ST_OK) begin
            push_point('0, dec_start, nxt, st, 1'b1);
            fail_sequence(fin, nxt);
         end else begin
            push_point(v, dec_start, nxt, ST_OK, fin);
            close_sequence(fin, nxt);
         end
      end else if (fin) begin
         push_point('0, dec_start, nxt, ST_TRUNCATED, 1'b1);
         clear_decoder();
      end else begin
         dec_pos = nxt;
      end
   endfunction

   // encode at the given width, whether or not that width is canonical
   function automatic void put_scalar(input scalar_type cp, input width_type w);
      case (w)
         WIDTH_ONE: begin
            append_byte({1'b0, cp[6:0]});
         end
         WIDTH_TWO: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         WIDTH_THREE: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic scalar_type pick_scalar(input width_type w);
      scalar_type v;
      case (w)
         WIDTH_ONE: v = scalar_type'($urandom_range(0, 'h7F));
         WIDTH_TWO: v = scalar_type'($urandom_range('h80, 'h7FF));
         WIDTH_THREE: begin
            v = scalar_type'($urandom_range('h800, 'hF7FF));
            if (v >= SURR_LO) begin
               v = v + 21'h800;
            end
         end
         default: v = scalar_type'($urandom_range('h10000, 'h10FFFF));
      endcase
      return v;
   endfunction

   function automatic void put_valid_scalar();
      width_type w;
      w = width_type'($urandom_range(1, 4));
      put_scalar(pick_scalar(w), w);
   endfunction

   function automatic logic [7:0] pick_non_cont();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ((b & CONT_MASK) == CONT_TAG) begin
         b[6] = 1'b1;
      end
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_type beat;
      int gaps;
      beat.data_byte = b;
      beat.final_byte = fin;
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      decode_byte(beat);
      beats_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gaps = $urandom_range(0, gap_max);
         if (gaps != 0) begin
            req_valid <= 1'b0;
            repeat (gaps) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
   endtask

   task automatic build_random_text();
      int kind;
      int cut;
      int spot;
      width_type w;
      text_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(1, 6)) put_valid_scalar();
      if (kind < 70) begin
         return;
      end
      case ($urandom_range(0, 5))
         0: begin
            spot = $urandom_range(0, text_bytes.size());
            if ($urandom_range(0, 1) == 0) begin
               text_bytes.insert(spot, 8'($urandom_range('h80, 'hBF)));
            end else begin
               text_bytes.insert(spot, 8'($urandom_range('hF8, 'hFF)));
            end
         end
         1: begin
            // end inside a sequence, now and then with a bad byte in it
            w = width_type'($urandom_range(2, 4));
            put_scalar(pick_scalar(w), w);
            cut = $urandom_range(1, w - 1);
            repeat (cut) void'(text_bytes.pop_back());
            if (cut < w - 1 && $urandom_range(0, 1) == 0) begin
               text_bytes[text_bytes.size() - 1] = pick_non_cont();
            end
            return;
         end
         2: begin
            w = width_type'($urandom_range(2, 4));
            put_scalar(pick_scalar(w), w);
            spot = text_bytes.size() - 1 - $urandom_range(0, w - 2);
            text_bytes[spot] = pick_non_cont();
         end
         3: begin
            w = width_type'($urandom_range(2, 4));
            case (w)
               WIDTH_TWO: put_scalar(scalar_type'($urandom_range(0, 'h7F)), w);
               WIDTH_THREE: put_scalar(scalar_type'($urandom_range(0, 'h7FF)), w);
               default: put_scalar(scalar_type'($urandom_range(0, 'hFFFF)), w);
            endcase
         end
         4: put_scalar(scalar_type'($urandom_range('hD800, 'hDFFF)), WIDTH_THREE);
         default: put_scalar(scalar_type'($urandom_range('h110000, 'h1FFFFF)), WIDTH_FOUR);
      endcase
      repeat ($urandom_range(0, 4)) put_valid_scalar();
   endtask

   task automatic test_valid_forms();
      text_bytes = {8'h00, 8'h7F};
      send_text();
      text_bytes = {8'hC2, 8'h80};
      send_text();
      text_bytes = {8'hEF, 8'hBF, 8'hBF};
      send_text();
      text_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
   endtask

   task automatic test_bad_lead();
      text_bytes = {8'h80};
      send_text();
      text_bytes = {8'hFF, 8'h41};
      send_text();
      text_bytes = {8'hF8, 8'hC2, 8'h80};
      send_text();
   endtask

   task automatic test_truncation();
      text_bytes = {8'hC2};
      send_text();
      text_bytes = {8'hE2, 8'h82};
      send_text();
      text_bytes = {8'hE2, 8'h41};
      send_text();
   endtask

   task automatic test_bad_continuation();
      text_bytes = {8'hC2, 8'h41};
      send_text();
   endtask

   task automatic test_non_canonical();
      text_bytes = {8'hC0, 8'h80};
      send_text();
      text_bytes = {8'hED, 8'hA0, 8'h80};
      send_text();
      text_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};
      send_text();
   endtask

   task automatic test_backpressure();
      int stop_at;
      stop_at = beats_sent + 40;
      gap_max = 0;
      hold_asked <= hold_asked + 1;
      while (beats_sent < stop_at) begin
         text_bytes.delete();
         repeat ($urandom_range(1, 6)) put_valid_scalar();
         send_text();
      end
      gap_max = 3;
   endtask

   task automatic test_random_texts();
      int stop_at;
      int texts;
      stop_at = beats_sent + 800;
      texts = 0;
      while (beats_sent < stop_at) begin
         if (texts % 8 == 0) begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
         build_random_text();
         send_text();
         texts++;
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, label, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t ns: result beat with nothing expected: expected none, actual %p",
                     $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            check_field("code_point", 32'(want.code_point), 32'(rsp_payload.code_point));
            check_field("start_offset", want.start_offset, rsp_payload.start_offset);
            check_field("end_offset", want.end_offset, rsp_payload.end_offset);
            check_field("status", 32'(want.status), 32'(rsp_payload.status));
            check_field("last_result", 32'(want.last_result), 32'(rsp_payload.last_result));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode = stall_kind_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(20, 120);
         end else begin
            mode_cycles--;
         end
         phase_count++;
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= ((phase_count % 5) < 2);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_valid_forms();
      test_bad_lead();
      test_truncation();
      test_bad_continuation();
      test_non_canonical();
      test_backpressure();
      test_random_texts();
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (pending_points.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (pending_points.size() != 0) begin
         $display("%0t ns: expected %0d more result beats, actual none",
                  $time, pending_points.size());
         error_count += pending_points.size();
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t ns: run timed out", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
